### design/mprf_pkg.sv
// ----------------------------------------------------------------------------
// mprf_pkg
// Shared constants, reset tables and memory command type for the
// management PHY register file.
// ----------------------------------------------------------------------------
package mprf_pkg;

    localparam int NUM_PHYS_DEF = 256;
    localparam int NUM_REGS_DEF = 32;
    localparam int TABLE_WORDS  = 32;

    localparam logic [8:0]  THRESHOLD_RESET = 9'd25;
    localparam int          SOFT_RESET_BIT  = 15;
    localparam logic [4:0]  REG_ID_HI       = 5'd2;
    localparam logic [4:0]  REG_ID_LO       = 5'd3;
    localparam logic [4:0]  REG_CONTROL     = 5'd0;

    localparam logic [15:0] TABLE_FIRST [TABLE_WORDS] = '{
        16'h3000, 16'h7809, 16'h0040, 16'h61d4, 16'h01e1, 16'h0000, 16'h0004, 16'h2001,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h1000, 16'h0001, 16'h0000, 16'h0000, 16'h0200, 16'h0600, 16'h0100, 16'h0000,
        16'h003c, 16'h0002, 16'h1f00, 16'h009a, 16'h002c, 16'h0000, 16'h0000, 16'h000b
    };

    localparam logic [15:0] TABLE_SECOND [TABLE_WORDS] = '{
        16'h1100, 16'h7949, 16'h0020, 16'h6061, 16'h0061, 16'h0000, 16'h0004, 16'h2001,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h3000,
        16'h0002, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0420, 16'h0000, 16'h0000, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h0000
    };

    typedef struct packed {
        logic wr;
        logic rd;
    } mem_cmd_t;

    function automatic logic [15:0] table_word(input logic second, input logic [4:0] idx);
        return second ? TABLE_SECOND[idx] : TABLE_FIRST[idx];
    endfunction

endpackage

### design/mprf_store.sv
// ----------------------------------------------------------------------------
// mprf_store
// Single-port register store, one row per PHY, registered read data.
// ----------------------------------------------------------------------------
module mprf_store #(
    parameter int ADDR_W = 13,
    parameter int DEPTH  = 8192
) (
    input  logic                clk,
    input  mprf_pkg::mem_cmd_t  cmd,
    input  logic [ADDR_W-1:0]   addr,
    input  logic [15:0]         wdata,
    output logic [15:0]         rdata
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/mprf_ctrl.sv
// ----------------------------------------------------------------------------
// mprf_ctrl
// Access sequencer: ID check, table load, read or write, result register.
// Rows not loaded since reset are loaded on first access through per-PHY valid bits.
// ----------------------------------------------------------------------------
module mprf_ctrl #(
    parameter int NUM_PHYS = mprf_pkg::NUM_PHYS_DEF,
    parameter int NUM_REGS = mprf_pkg::NUM_REGS_DEF,
    parameter int PHY_W    = 8,
    parameter int REG_W    = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [8:0]               threshold,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     kind,
    input  logic [7:0]               phy_id,
    input  logic [4:0]               reg_addr,
    input  logic [15:0]              write_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [15:0]              read_data,
    output logic                     reset_done,
    output mprf_pkg::mem_cmd_t       mem_cmd,
    output logic [PHY_W+REG_W-1:0]   mem_addr,
    output logic [15:0]              mem_wdata,
    input  logic [15:0]              mem_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD2,
        S_RD3,
        S_CHK,
        S_LOAD,
        S_ACC,
        S_RWAIT,
        S_DONE
    } state_t;

    localparam logic [REG_W-1:0] LAST_WORD = REG_W'(NUM_REGS - 1);

    state_t              state_reg, state_next;
    logic [NUM_PHYS-1:0] row_valid_reg, row_valid_next;
    logic                kind_reg, kind_next;
    logic [7:0]          phy_reg, phy_next;
    logic [4:0]          addr_reg, addr_next;
    logic [15:0]         data_reg, data_next;
    logic                second_reg, second_next;
    logic [15:0]         id_hi_reg, id_hi_next;
    logic [REG_W-1:0]    cnt_reg, cnt_next;
    logic [15:0]         result_reg, result_next;
    logic                did_reset_reg, did_reset_next;
    logic                out_valid_reg, out_valid_next;
    logic [15:0]         read_data_reg, read_data_next;
    logic                reset_done_reg, reset_done_next;

    logic                phy_in_range;
    logic                reg_in_range;
    logic                soft_reset;
    logic [REG_W-1:0]    word_sel;
    logic [PHY_W-1:0]    row_idx;

    assign phy_in_range = {1'b0, phy_id} < 9'(NUM_PHYS);
    assign reg_in_range = {1'b0, addr_reg} < 6'(NUM_REGS);
    assign soft_reset   = (addr_reg == mprf_pkg::REG_CONTROL)
                          && data_reg[mprf_pkg::SOFT_RESET_BIT];
    assign row_idx      = phy_reg[PHY_W-1:0];
    assign mem_addr     = {row_idx, word_sel};

    always_comb
    begin
        state_next      = state_reg;
        row_valid_next  = row_valid_reg;
        kind_next       = kind_reg;
        phy_next        = phy_reg;
        addr_next       = addr_reg;
        data_next       = data_reg;
        second_next     = second_reg;
        id_hi_next      = id_hi_reg;
        cnt_next        = cnt_reg;
        result_next     = result_reg;
        did_reset_next  = did_reset_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        read_data_next  = read_data_reg;
        reset_done_next = reset_done_reg;
        mem_cmd         = '0;
        mem_wdata       = data_reg;
        word_sel        = addr_reg[REG_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next      = kind;
                    phy_next       = phy_id;
                    addr_next      = reg_addr;
                    data_next      = write_data;
                    second_next    = {1'b0, phy_id} >= threshold;
                    result_next    = '0;
                    did_reset_next = 1'b0;
                    cnt_next       = '0;
                    if (!phy_in_range)
                    begin
                        state_next = S_DONE;
                    end
                    else if (!row_valid_reg[phy_id[PHY_W-1:0]])
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_RD2;
                    end
                end
            end
            S_RD2:
            begin
                word_sel    = REG_W'(mprf_pkg::REG_ID_HI);
                mem_cmd.rd  = 1'b1;
                state_next  = S_RD3;
            end
            S_RD3:
            begin
                word_sel    = REG_W'(mprf_pkg::REG_ID_LO);
                mem_cmd.rd  = 1'b1;
                id_hi_next  = mem_rdata;
                state_next  = S_CHK;
            end
            S_CHK:
            begin
                cnt_next   = '0;
                state_next = (id_hi_reg == '0 && mem_rdata == '0) ? S_LOAD : S_ACC;
            end
            S_LOAD:
            begin
                word_sel    = cnt_reg;
                mem_wdata   = mprf_pkg::table_word(second_reg, 5'(cnt_reg));
                mem_cmd.wr  = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == LAST_WORD)
                begin
                    row_valid_next[row_idx] = 1'b1;
                    did_reset_next          = 1'b1;
                    state_next              = S_ACC;
                end
            end
            S_ACC:
            begin
                cnt_next = '0;
                if (kind_reg)
                begin
                    if (reg_in_range)
                    begin
                        mem_cmd.rd = 1'b1;
                        state_next = S_RWAIT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (soft_reset)
                begin
                    // a load already done for this beat gives the same contents
                    state_next = did_reset_reg ? S_DONE : S_LOAD;
                end
                else
                begin
                    mem_cmd.wr = reg_in_range;
                    state_next = S_DONE;
                end
            end
            S_RWAIT:
            begin
                result_next = mem_rdata;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    read_data_next  = result_reg;
                    reset_done_next = did_reset_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        phy_reg        <= phy_next;
        addr_reg       <= addr_next;
        data_reg       <= data_next;
        second_reg     <= second_next;
        id_hi_reg      <= id_hi_next;
        cnt_reg        <= cnt_next;
        result_reg     <= result_next;
        did_reset_reg  <= did_reset_next;
        read_data_reg  <= read_data_next;
        reset_done_reg <= reset_done_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign read_data  = read_data_reg;
    assign reset_done = reset_done_reg;

endmodule

### design/mdio_phy_register_file_unit.sv
// ----------------------------------------------------------------------------
// mdio_phy_register_file_unit
// Per beat: ID word check on a loaded PHY, then the read or write. The first access
// to a PHY since reset, cleared ID words or a soft reset force a table load, one word
// a cycle on the store.
// Throughput: one beat at a time; the next is taken once the result has moved into
// the output register, where a finished result waits until out_ready.
// Reset: control and per-PHY valid bits cleared at once, threshold set to 25.
// ----------------------------------------------------------------------------
module mdio_phy_register_file_unit #(
    parameter int NUM_PHYS = mprf_pkg::NUM_PHYS_DEF,
    parameter int NUM_REGS = mprf_pkg::NUM_REGS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  phy_id,
    input  logic [4:0]  reg_addr,
    input  logic [15:0] write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] read_data,
    output logic        reset_done
);

    localparam int PHY_W  = (NUM_PHYS > 1) ? $clog2(NUM_PHYS) : 1;
    localparam int REG_W  = $clog2(NUM_REGS);
    localparam int ADDR_W = PHY_W + REG_W;
    localparam int DEPTH  = NUM_PHYS << REG_W;

    logic [8:0]          second_model_first_id_reg;
    mprf_pkg::mem_cmd_t  mem_cmd;
    logic [ADDR_W-1:0]   mem_addr;
    logic [15:0]         mem_wdata;
    logic [15:0]         mem_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_model_first_id_reg <= mprf_pkg::THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            second_model_first_id_reg <= cfg_data;
        end
    end

    mprf_ctrl #(
        .NUM_PHYS (NUM_PHYS),
        .NUM_REGS (NUM_REGS),
        .PHY_W    (PHY_W),
        .REG_W    (REG_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .threshold  (second_model_first_id_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .phy_id     (phy_id),
        .reg_addr   (reg_addr),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .reset_done (reset_done),
        .mem_cmd    (mem_cmd),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .mem_rdata  (mem_rdata)
    );

    mprf_store #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_store (
        .clk   (clk),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_cmd.wr && mem_cmd.rd))
        else $error("store read and written in one cycle");

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again without processing");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_cmd.wr |-> !in_ready)
        else $error("store written while idle");

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for mdio_phy_register_file_unit. A driver and a
// monitor, both clocked, move access and result beats with random idle
// cycles and repeated long receiver hold-offs. Every accepted access is run
// through a local model of the PHY bank (power-on load, soft reset,
// threshold-selected defaults) and each result beat is checked against
// the oldest prediction. The threshold register is rewritten between
// phases, extremes included.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic       ACCESS_WRITE = 1'b0;
    localparam logic       ACCESS_READ  = 1'b1;
    localparam logic [4:0] REG_CTRL     = 5'd0;
    localparam logic [4:0] REG_ID_HI    = 5'd2;
    localparam logic [4:0] REG_ID_LO    = 5'd3;
    localparam int         SOFT_RST_BIT = 15;
    localparam int         PHASE_ITEMS  = 200;
    localparam int         QUIET_LIMIT  = 5000;
    localparam int         HOLD_CYCLES  = 400;

    localparam logic [0:31][15:0] DEFAULTS_FIRST = {
        16'h3000, 16'h7809, 16'h0040, 16'h61d4, 16'h01e1, 16'h0000, 16'h0004, 16'h2001,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h1000, 16'h0001, 16'h0000, 16'h0000, 16'h0200, 16'h0600, 16'h0100, 16'h0000,
        16'h003c, 16'h0002, 16'h1f00, 16'h009a, 16'h002c, 16'h0000, 16'h0000, 16'h000b
    };

    localparam logic [0:31][15:0] DEFAULTS_SECOND = {
        16'h1100, 16'h7949, 16'h0020, 16'h6061, 16'h0061, 16'h0000, 16'h0004, 16'h2001,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h3000,
        16'h0002, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0420, 16'h0000, 16'h0000, 16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h0000
    };

    typedef struct packed {
        logic        kind;
        logic [7:0]  phy;
        logic [4:0]  regnum;
        logic [15:0] wdata;
    } mgmt_access_t;

    typedef struct packed {
        logic [15:0] rdata;
        logic        reset_flag;
    } mgmt_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [8:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        kind = 1'b0;
    logic [7:0]  phy_id = '0;
    logic [4:0]  reg_addr = '0;
    logic [15:0] write_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] read_data;
    logic        reset_done;

    logic [15:0]  bank_words [256][32];
    logic [8:0]   model_threshold = 9'd25;
    mgmt_access_t pending_accesses [$];
    mgmt_reply_t  expected_replies [$];
    mgmt_access_t offered;
    mgmt_reply_t  want;
    int           send_wait = 0;
    int           send_calm = 0;
    int           recv_wait = 0;
    int           recv_calm = 0;
    int           results_seen = 0;
    int           mismatches = 0;
    int           quiet_cycles = 0;

    mdio_phy_register_file_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .phy_id     (phy_id),
        .reg_addr   (reg_addr),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .reset_done (reset_done)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void load_defaults(input logic [7:0] phy);
        for (int r = 0; r < 32; r++)
        begin
            if ({1'b0, phy} < model_threshold)
                bank_words[phy][r] = DEFAULTS_FIRST[r];
            else
                bank_words[phy][r] = DEFAULTS_SECOND[r];
        end
    endfunction

    function automatic mgmt_reply_t phy_bank_access(input mgmt_access_t a);
        mgmt_reply_t r;
        r.rdata = '0;
        r.reset_flag = 1'b0;
        if (bank_words[a.phy][REG_ID_HI] == 16'h0 && bank_words[a.phy][REG_ID_LO] == 16'h0)
        begin
            load_defaults(a.phy);
            r.reset_flag = 1'b1;
        end
        if (a.kind == ACCESS_READ)
            r.rdata = bank_words[a.phy][a.regnum];
        else if (a.regnum == REG_CTRL && a.wdata[SOFT_RST_BIT])
        begin
            load_defaults(a.phy);
            r.reset_flag = 1'b1;
        end
        else
            bank_words[a.phy][a.regnum] = a.wdata;
        return r;
    endfunction

    function automatic void queue_access(input logic k, input logic [7:0] phy,
                                         input logic [4:0] regnum, input logic [15:0] wdata);
        mgmt_access_t a;
        a.kind = k;
        a.phy = phy;
        a.regnum = regnum;
        a.wdata = wdata;
        pending_accesses.push_back(a);
    endfunction

    // PHY numbers cluster around the threshold and a small pool so that
    // reloads and revisits are frequent
    function automatic mgmt_access_t random_access(input logic [8:0] thr);
        mgmt_access_t a;
        int pick;
        int p;
        pick = $urandom_range(0, 9);
        if (pick < 5)
        begin
            p = int'(thr) + int'($urandom_range(0, 3)) - 2;
            if (p < 0)
                p = 0;
            if (p > 255)
                p = 255;
        end
        else if (pick < 8)
            p = $urandom_range(0, 7);
        else
            p = $urandom_range(0, 255);
        a.phy = p[7:0];
        a.kind = $urandom_range(0, 1) ? ACCESS_READ : ACCESS_WRITE;
        case ($urandom_range(0, 5))
            0:       a.regnum = REG_CTRL;
            1:       a.regnum = REG_ID_HI;
            2:       a.regnum = REG_ID_LO;
            default: a.regnum = 5'($urandom_range(0, 31));
        endcase
        case ($urandom_range(0, 7))
            0:       a.wdata = 16'h0000;
            1:       a.wdata = 16'hffff;
            default: a.wdata = 16'($urandom_range(0, 65535));
        endcase
        return a;
    endfunction

    task automatic queue_random_phase(input int count, input logic [8:0] thr);
        mgmt_access_t a;
        int n;
        n = 0;
        while (n < count)
        begin
            a = random_access(thr);
            if ($urandom_range(0, 19) == 0)
            begin
                // clear both ID words so the next access forces a power-on load
                queue_access(ACCESS_WRITE, a.phy, REG_ID_HI, 16'h0000);
                queue_access(ACCESS_WRITE, a.phy, REG_ID_LO, 16'h0000);
                n += 2;
            end
            pending_accesses.push_back(a);
            n++;
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_accesses.size() != 0 || in_valid || expected_replies.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_threshold(input logic [8:0] value);
        wait_idle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        model_threshold = value;
        @(negedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] exp_val,
                                   input logic [15:0] got_val);
        if (mismatches < 10)
            $display("%0t ns: %s mismatch: expected %h, got %h", $realtime, what,
                     exp_val, got_val);
        mismatches++;
    endtask

    // access beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_replies.push_back(phy_bank_access(offered));
            if (!in_valid || in_ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (pending_accesses.size() != 0)
                begin
                    offered = pending_accesses.pop_front();
                    in_valid <= 1'b1;
                    kind <= offered.kind;
                    phy_id <= offered.phy;
                    reg_addr <= offered.regnum;
                    write_data <= offered.wdata;
                    if (send_calm > 0)
                    begin
                        send_calm--;
                        send_wait = 0;
                    end
                    else
                    begin
                        send_wait = $urandom_range(0, 3);
                        if ($urandom_range(0, 31) == 0)
                            send_calm = $urandom_range(10, 40);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_replies.size() == 0)
                    report_mismatch("unexpected result beat", 16'h0000, read_data);
                else
                begin
                    want = expected_replies.pop_front();
                    if (read_data !== want.rdata)
                        report_mismatch("read_data", want.rdata, read_data);
                    if (reset_done !== want.reset_flag)
                        report_mismatch("reset_done", {15'h0, want.reset_flag},
                                        {15'h0, reset_done});
                end
                results_seen++;
                // long hold-off so the block backs up and stalls its input
                if (results_seen % 500 == 250)
                    recv_wait = HOLD_CYCLES;
                else if (recv_calm > 0)
                begin
                    recv_calm--;
                    recv_wait = 0;
                end
                else
                begin
                    recv_wait = $urandom_range(0, 3);
                    if ($urandom_range(0, 31) == 0)
                        recv_calm = $urandom_range(10, 40);
                end
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [8:0] thr;
        for (int p = 0; p < 256; p++)
        begin
            for (int r = 0; r < 32; r++)
                bank_words[p][r] = 16'h0000;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // power-on loads either side of the threshold
        queue_access(ACCESS_READ,  8'd0,   REG_CTRL, 16'hffff);
        queue_access(ACCESS_READ,  8'd0,   REG_CTRL, 16'h0000);
        queue_access(ACCESS_READ,  8'd24,  5'd1,     16'h0000);
        queue_access(ACCESS_READ,  8'd25,  5'd1,     16'h0000);
        queue_access(ACCESS_READ,  8'd255, 5'd31,    16'hffff);
        queue_access(ACCESS_WRITE, 8'd0,   5'd31,    16'hffff);
        queue_access(ACCESS_READ,  8'd0,   5'd31,    16'h0000);
        queue_access(ACCESS_WRITE, 8'd0,   5'd5,     16'h0000);
        // soft reset, then a control write without it
        queue_access(ACCESS_WRITE, 8'd0,   REG_CTRL, 16'h8000);
        queue_access(ACCESS_READ,  8'd0,   5'd31,    16'h0000);
        queue_access(ACCESS_WRITE, 8'd0,   REG_CTRL, 16'h7fff);
        queue_access(ACCESS_READ,  8'd0,   REG_CTRL, 16'h0000);
        // power-on and soft reset on the same beat
        queue_access(ACCESS_WRITE, 8'd1,   REG_CTRL, 16'hffff);
        queue_access(ACCESS_READ,  8'd1,   REG_CTRL, 16'h0000);
        // zeroed ID words trigger a fresh load
        queue_access(ACCESS_WRITE, 8'd2,   REG_ID_HI, 16'h0000);
        queue_access(ACCESS_WRITE, 8'd2,   REG_ID_LO, 16'h0000);
        queue_access(ACCESS_READ,  8'd2,   5'd4,     16'h0000);
        queue_access(ACCESS_WRITE, 8'd128, 5'd16,    16'ha5a5);
        queue_access(ACCESS_READ,  8'd128, 5'd16,    16'h0000);
        queue_access(ACCESS_WRITE, 8'd127, 5'd15,    16'h5a5a);
        queue_access(ACCESS_READ,  8'd200, 5'd27,    16'h0000);
        queue_access(ACCESS_WRITE, 8'd3,   5'd1,     16'h8000);
        queue_access(ACCESS_READ,  8'd3,   5'd1,     16'h0000);

        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0:       thr = 9'd256;
                1:       thr = 9'd0;
                2:       thr = 9'd1;
                3:       thr = 9'd255;
                4:       thr = 9'd128;
                5:       thr = 9'($urandom_range(0, 256));
                default: thr = 9'd25;
            endcase
            write_threshold(thr);
            queue_random_phase(PHASE_ITEMS, thr);
        end

        wait_idle();
        repeat (60) @(posedge clk);
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
